FILE: rtl/ic2d_pkg.sv
// ic2d_pkg: shared constants for the streaming 2d convolution block
// no dependencies; imported by the top level, its checker and the testbench

package ic2d_pkg;

    localparam int CFG_W     = 11;
    localparam int KDIM_W    = 3;
    localparam int KIND_W    = 2;
    localparam int PIX_W     = 8;
    localparam int CIDX_W    = 6;
    localparam int COEF_W    = 18;
    localparam int RES_W     = 20;
    localparam int FRAC_BITS = 12;
    localparam int ROUND_HALF = 2048;
    localparam int RES_MAX   = 524287;
    localparam int RES_MIN   = -524288;

    localparam logic [KIND_W-1:0] KIND_COEF  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAD   = 2'd2;

    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_KERNEL_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_KERNEL_HEIGHT = 2'd3;

    localparam logic [CFG_W-1:0]  IMAGE_DIM_RESET  = 11'd1024;
    localparam logic [KDIM_W-1:0] KERNEL_DIM_RESET = 3'd3;

endpackage

FILE: rtl/image_convolution_2d_top.sv
// image_convolution_2d_top: zero padded 2d convolution over a raster pixel stream
// throughput: one transaction per cycle while the output is not stalled,
//   set by the single line memory read-modify-write
// reset: synchronous active low, sets geometry to 1024x1024 with a 3x3 kernel,
//   clears kernel store, positions and valids
// depends on ic2d_pkg

module image_convolution_2d_top
    import ic2d_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_KERNEL = 7
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [KIND_W-1:0]        s_kind,
    input  logic [PIX_W-1:0]         s_pixel_value,
    input  logic [CIDX_W-1:0]        s_coef_index,
    input  logic signed [COEF_W-1:0] s_coef_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [RES_W-1:0]  m_result_value,
    output logic                     m_frame_last
);

    localparam int KD     = MAX_KERNEL * MAX_KERNEL;
    localparam int KI_W   = (KD > 1) ? $clog2(KD) : 1;
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int KW_W   = $clog2(MAX_KERNEL + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2 * MAX_KERNEL + 1);
    localparam int POS_W  = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_KERNEL) + 1);
    localparam int CW     = ((HW > WW) ? HW : WW) + 2;
    localparam int LROWS  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int NLEV   = $clog2(KD);
    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int SUM_W  = PROD_W + NLEV;
    localparam int RW     = SUM_W + 1;

    typedef struct packed {
        logic                     is_load;
        logic                     is_stream;
        logic                     emit;
        logic                     last;
        logic [AW-1:0]            col;
        logic [HW-1:0]            oi;
        logic [AW-1:0]            oj;
        logic [PIX_W-1:0]         pix;
        logic [CIDX_W-1:0]        cidx;
        logic signed [COEF_W-1:0] cval;
    } st1_t;

    typedef logic [LROWS-1:0][PIX_W-1:0] line_word_t;

    // configuration
    logic [CFG_W-1:0]  cfg_w_reg, cfg_h_reg;
    logic [KDIM_W-1:0] cfg_kw_reg, cfg_kh_reg;
    logic [WW-1:0]     w_eff;
    logic [HW-1:0]     h_eff;
    logic [KW_W-1:0]   kw_eff, kh_eff, cx, cy;
    logic [POS_W-1:0]  lag;

    // positions
    logic [POS_W-1:0] in_pos_reg, in_pos_next;
    logic [AW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [AW-1:0]    out_col_reg, out_col_next;
    logic [HW-1:0]    out_row_reg, out_row_next;

    logic adv, acc, is_stream, emit, last, in_frame;
    logic [PIX_W-1:0] pix_in;

    st1_t st1_reg;
    logic st1_valid_reg;

    line_word_t line_mem [MAX_WIDTH];
    line_word_t mem_rd_reg, fwd_data_reg, line_word, wr_word;
    logic       fwd_reg, mem_we;

    logic [PIX_W-1:0]         win_reg [MAX_KERNEL][MAX_KERNEL];
    logic [PIX_W-1:0]         tap [MAX_KERNEL];
    logic signed [COEF_W-1:0] kern_reg [KD];

    logic             st2_valid_reg, st2_last_reg;
    logic [HW-1:0]    st2_oi_reg;
    logic [AW-1:0]    st2_oj_reg;
    logic [MAX_KERNEL-1:0] row_ok, col_ok;
    logic [PIX_W-1:0] lane_pix_c [KD];

    logic                     st3_valid_reg, st3_last_reg;
    logic [PIX_W-1:0]         lane_pix_reg [KD];
    logic signed [COEF_W-1:0] lane_coef_reg [KD];

    logic signed [SUM_W-1:0] sum_reg [NLEV+1][KD];
    logic [NLEV:0]           vld_reg, lst_reg;

    logic signed [RW-1:0] s_ext, mag, rnd;
    logic signed [RES_W-1:0] res_sat;

    logic                    m_valid_reg, m_frame_last_reg;
    logic signed [RES_W-1:0] m_result_value_reg;

    // geometry with clamping
    always_comb begin
        if (cfg_w_reg == '0)                w_eff = WW'(1);
        else if (int'(cfg_w_reg) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
        else                                w_eff = WW'(cfg_w_reg);
        if (cfg_h_reg == '0)                 h_eff = HW'(1);
        else if (int'(cfg_h_reg) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
        else                                 h_eff = HW'(cfg_h_reg);
        if (cfg_kw_reg == '0)                  kw_eff = KW_W'(1);
        else if (int'(cfg_kw_reg) > MAX_KERNEL) kw_eff = KW_W'(MAX_KERNEL);
        else                                   kw_eff = KW_W'(cfg_kw_reg);
        if (cfg_kh_reg == '0)                  kh_eff = KW_W'(1);
        else if (int'(cfg_kh_reg) > MAX_KERNEL) kh_eff = KW_W'(MAX_KERNEL);
        else                                   kh_eff = KW_W'(cfg_kh_reg);
        cx  = kw_eff >> 1;
        cy  = kh_eff >> 1;
        lag = POS_W'(cy) * POS_W'(w_eff) + POS_W'(cx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg  <= IMAGE_DIM_RESET;
            cfg_h_reg  <= IMAGE_DIM_RESET;
            cfg_kw_reg <= KERNEL_DIM_RESET;
            cfg_kh_reg <= KERNEL_DIM_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   cfg_w_reg  <= cfg_wdata;
                CFG_IMAGE_HEIGHT:  cfg_h_reg  <= cfg_wdata;
                CFG_KERNEL_WIDTH:  cfg_kw_reg <= cfg_wdata[KDIM_W-1:0];
                CFG_KERNEL_HEIGHT: cfg_kh_reg <= cfg_wdata[KDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // input side
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign acc       = s_valid && adv;
    assign is_stream = (s_kind == KIND_PIXEL) || (s_kind == KIND_PAD);
    assign in_frame  = int'(in_row_reg) < int'(h_eff);
    assign emit      = is_stream && (in_pos_reg >= lag);
    assign last      = emit && (int'(out_row_reg) == int'(h_eff) - 1)
                            && (int'(out_col_reg) == int'(w_eff) - 1);
    assign pix_in    = (s_kind == KIND_PIXEL && in_frame) ? s_pixel_value : '0;

    always_comb begin
        in_pos_next  = in_pos_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we) begin
            in_pos_next  = '0;
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (acc && is_stream) begin
            if (last) begin
                in_pos_next  = '0;
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                in_pos_next = in_pos_reg + POS_W'(1);
                if (int'(in_col_reg) == int'(w_eff) - 1) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end else begin
                    in_col_next = in_col_reg + AW'(1);
                end
                if (emit) begin
                    if (int'(out_col_reg) == int'(w_eff) - 1) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + HW'(1);
                    end else begin
                        out_col_next = out_col_reg + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_pos_reg  <= '0;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_pos_reg  <= in_pos_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // stage 1: line memory read issued on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (adv) begin
            st1_valid_reg <= acc && (is_stream || s_kind == KIND_COEF);
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            st1_reg.is_load   <= (s_kind == KIND_COEF);
            st1_reg.is_stream <= is_stream;
            st1_reg.emit      <= emit;
            st1_reg.last      <= last;
            st1_reg.col       <= in_col_reg;
            st1_reg.oi        <= out_row_reg;
            st1_reg.oj        <= out_col_reg;
            st1_reg.pix       <= pix_in;
            st1_reg.cidx      <= s_coef_index;
            st1_reg.cval      <= s_coef_value;
        end
    end

    // read-modify-write of the line memory, forwarding when the same column repeats
    assign line_word = fwd_reg ? fwd_data_reg : mem_rd_reg;
    assign mem_we    = adv && st1_valid_reg && st1_reg.is_stream;

    always_comb begin
        wr_word[0] = st1_reg.pix;
        for (int r = 1; r < LROWS; r++) begin
            wr_word[r] = line_word[r-1];
        end
        tap[0] = st1_reg.pix;
        for (int m = 1; m < MAX_KERNEL; m++) begin
            tap[m] = line_word[m-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[st1_reg.col] <= wr_word;
        end
        if (acc) begin
            mem_rd_reg <= line_mem[in_col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (acc) begin
            fwd_reg <= mem_we && (st1_reg.col == in_col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            fwd_data_reg <= wr_word;
        end
    end

    // window shift
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            for (int m = 0; m < MAX_KERNEL; m++) begin
                win_reg[m][0] <= tap[m];
                for (int n = 1; n < MAX_KERNEL; n++) begin
                    win_reg[m][n] <= win_reg[m][n-1];
                end
            end
        end
    end

    // kernel store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KD; k++) begin
                kern_reg[k] <= '0;
            end
        end else if (adv && st1_valid_reg && st1_reg.is_load && int'(st1_reg.cidx) < KD) begin
            kern_reg[KI_W'(st1_reg.cidx)] <= st1_reg.cval;
        end
    end

    // stage 2: border masks and lane mapping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (adv) begin
            st2_valid_reg <= st1_valid_reg && st1_reg.is_stream && st1_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st2_last_reg <= st1_reg.last;
            st2_oi_reg   <= st1_reg.oi;
            st2_oj_reg   <= st1_reg.oj;
        end
    end

    always_comb begin
        logic [CW-1:0] rs, cs;
        rs = CW'(st2_oi_reg) + CW'(cy);
        cs = CW'(st2_oj_reg) + CW'(cx);
        for (int m = 0; m < MAX_KERNEL; m++) begin
            row_ok[m] = (rs >= CW'(m)) && (rs - CW'(m) < CW'(h_eff));
            col_ok[m] = (cs >= CW'(m)) && (cs - CW'(m) < CW'(w_eff));
        end
    end

    always_comb begin
        for (int k = 0; k < KD; k++) begin
            lane_pix_c[k] = '0;
        end
        for (int m = 0; m < MAX_KERNEL; m++) begin
            for (int n = 0; n < MAX_KERNEL; n++) begin
                if (m < int'(kh_eff) && n < int'(kw_eff)) begin
                    lane_pix_c[KI_W'(m * int'(kw_eff) + n)] =
                        (row_ok[m] && col_ok[n]) ? win_reg[m][n] : '0;
                end
            end
        end
    end

    // stage 3: lane operands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
        end else if (adv) begin
            st3_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st3_last_reg <= st2_last_reg;
            for (int k = 0; k < KD; k++) begin
                lane_pix_reg[k]  <= lane_pix_c[k];
                lane_coef_reg[k] <= kern_reg[k];
            end
        end
    end

    // products and adder tree
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NLEV-1:0], st3_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lst_reg[0] <= st3_last_reg;
            for (int l = 0; l < NLEV; l++) begin
                lst_reg[l+1] <= lst_reg[l];
            end
            for (int k = 0; k < KD; k++) begin
                sum_reg[0][k] <= SUM_W'($signed({1'b0, lane_pix_reg[k]}))
                               * SUM_W'(lane_coef_reg[k]);
            end
            for (int l = 0; l < NLEV; l++) begin
                for (int i = 0; i < KD; i++) begin
                    if (2 * i + 1 < ((KD + (1 << l) - 1) >> l)) begin
                        sum_reg[l+1][i] <= sum_reg[l][2*i] + sum_reg[l][2*i+1];
                    end else if (2 * i < ((KD + (1 << l) - 1) >> l)) begin
                        sum_reg[l+1][i] <= sum_reg[l][2*i];
                    end
                end
            end
        end
    end

    // rounding half away from zero and saturation
    always_comb begin
        s_ext = RW'(sum_reg[NLEV][0]);
        if (s_ext < 0) begin
            mag = ((-s_ext) + RW'(ROUND_HALF)) >>> FRAC_BITS;
            rnd = -mag;
        end else begin
            mag = (s_ext + RW'(ROUND_HALF)) >>> FRAC_BITS;
            rnd = mag;
        end
        if (rnd > RW'(RES_MAX))      res_sat = RES_W'(RES_MAX);
        else if (rnd < RW'(RES_MIN)) res_sat = RES_W'(RES_MIN);
        else                         res_sat = rnd[RES_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[NLEV];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && vld_reg[NLEV]) begin
            m_result_value_reg <= res_sat;
            m_frame_last_reg   <= lst_reg[NLEV];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_frame_last   = m_frame_last_reg;

endmodule

FILE: rtl/ic2d_checker.sv
// ic2d_checker: port level checks on the convolution top level, with its bind
// depends on ic2d_pkg and image_convolution_2d_top

module ic2d_checker
    import ic2d_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [RES_W-1:0] m_result_value,
    input logic                    m_frame_last
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_frame_last))
        else $error("result changed while stalled");

    // nothing pending straight after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input is taken whenever the output register is free
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // input is taken whenever the output transaction completes
    a_ready_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

bind image_convolution_2d_top ic2d_checker u_ic2d_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_frame_last   (m_frame_last)
);

FILE: tb/tb_image_convolution_2d_top.sv
// testbench for image_convolution_2d_top: random and directed pixel frames with live prediction
// scoreboard class predicts each output pixel at input acceptance and checks results in order
// depends on ic2d_pkg and rtl/image_convolution_2d_top.sv

module tb_image_convolution_2d_top;
    import ic2d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 1024;
    localparam int MAX_K      = 7;
    localparam int KSTORE_N   = MAX_K * MAX_K;
    localparam int LINE_DEPTH = (MAX_K - 1) * MAX_W + MAX_K;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [RES_W-1:0] value;
        logic                    last;
    } conv_result_t;

    class conv_scoreboard;
        int unsigned            img_w, img_h, ker_w, ker_h;
        bit [PIX_W-1:0]         line_mem [LINE_DEPTH];
        logic signed [COEF_W-1:0] coef_mem [KSTORE_N];
        int unsigned            in_pos, out_pos;
        conv_result_t           expected_q [$];
        int                     errors;
        bit                     frame_done;

        function new();
            img_w = MAX_W;
            img_h = MAX_H;
            ker_w = 3;
            ker_h = 3;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (coef_mem[i]) coef_mem[i] = '0;
            in_pos = 0;
            out_pos = 0;
            errors = 0;
            frame_done = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:   img_w = 32'(val);
                CFG_IMAGE_HEIGHT:  img_h = 32'(val);
                CFG_KERNEL_WIDTH:  ker_w = 32'(val[KDIM_W-1:0]);
                CFG_KERNEL_HEIGHT: ker_h = 32'(val[KDIM_W-1:0]);
                default: ;
            endcase
            in_pos = 0;
            out_pos = 0;
            frame_done = 0;
        endfunction

        function logic signed [RES_W-1:0] convolve(int unsigned p, int unsigned w,
                                                   int unsigned h, int unsigned kw,
                                                   int unsigned kh);
            int     row, col, r, c, cy, cx;
            longint acc, mag;
            row = p / w;
            col = p % w;
            cy = kh / 2;
            cx = kw / 2;
            acc = 0;
            for (int m = 0; m < kh; m++) begin
                r = row + cy - m;
                if (r < 0 || r >= h) continue;
                for (int n = 0; n < kw; n++) begin
                    c = col + cx - n;
                    if (c < 0 || c >= w) continue;
                    acc += longint'(line_mem[(r * w + c) % LINE_DEPTH])
                         * longint'(coef_mem[m * kw + n]);
                end
            end
            if (acc >= 0) mag = (acc + ROUND_HALF) >>> FRAC_BITS;
            else mag = -((-acc + ROUND_HALF) >>> FRAC_BITS);
            if (mag > RES_MAX) mag = RES_MAX;
            if (mag < RES_MIN) mag = RES_MIN;
            return mag[RES_W-1:0];
        endfunction

        function void note_input(logic [KIND_W-1:0] kind, logic [PIX_W-1:0] pix,
                                 logic [CIDX_W-1:0] cidx, logic signed [COEF_W-1:0] cval);
            int unsigned  w, h, kw, kh, total, lag;
            conv_result_t res;
            if (kind == KIND_COEF) begin
                if (cidx < KSTORE_N) coef_mem[cidx] = cval;
                return;
            end
            if (kind == KIND_NONE) return;
            w = clamp_dim(img_w, MAX_W);
            h = clamp_dim(img_h, MAX_H);
            kw = clamp_dim(ker_w, MAX_K);
            kh = clamp_dim(ker_h, MAX_K);
            total = w * h;
            lag = (kh / 2) * w + kw / 2;
            if (in_pos < total)
                line_mem[in_pos % LINE_DEPTH] = (kind == KIND_PIXEL) ? pix : '0;
            if (in_pos < lag) begin
                in_pos++;
                return;
            end
            res.value = convolve(out_pos, w, h, kw, kh);
            res.last = (out_pos >= total - 1);
            expected_q.push_back(res);
            if (res.last) begin
                in_pos = 0;
                out_pos = 0;
                frame_done = 1;
            end else begin
                in_pos++;
                out_pos++;
            end
        endfunction

        function void check_result(logic signed [RES_W-1:0] value, logic last);
            conv_result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction: result_value %0d frame_last %0b",
                       value, last);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (value !== exp_r.value) begin
                $error("result_value expected %0d actual %0d", exp_r.value, value);
                errors++;
            end
            if (last !== exp_r.last) begin
                $error("frame_last expected %0b actual %0b", exp_r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                     aclk = 0;
    logic                     aresetn = 0;
    logic                     cfg_we = 0;
    logic [1:0]               cfg_index = '0;
    logic [CFG_W-1:0]         cfg_wdata = '0;
    logic                     s_valid = 0;
    logic                     s_ready;
    logic [KIND_W-1:0]        s_kind = '0;
    logic [PIX_W-1:0]         s_pixel_value = '0;
    logic [CIDX_W-1:0]        s_coef_index = '0;
    logic signed [COEF_W-1:0] s_coef_value = '0;
    logic                     m_valid;
    logic                     m_ready = 0;
    logic signed [RES_W-1:0]  m_result_value;
    logic                     m_frame_last;

    conv_scoreboard sb = new();
    int  idle_pct = 0;
    bit  quiet = 0;
    int  random_items = 0;
    int  results_seen = 0;

    always #4 aclk = ~aclk;

    image_convolution_2d_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_pixel_value  (s_pixel_value),
        .s_coef_index   (s_coef_index),
        .s_coef_value   (s_coef_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_frame_last   (m_frame_last)
    );

    // result side: random stall bursts, one long hold-off to back the block up
    initial begin
        int  stall_left;
        bit  held;
        stall_left = 0;
        held = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= 200) begin
                held = 1;
                m_ready = 0;
                repeat (400) @(negedge aclk);
            end
            if (stall_left > 0) begin
                m_ready = 0;
                stall_left--;
            end else if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                m_ready = 0;
                stall_left = $urandom_range(0, 8);
            end else begin
                m_ready = 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_result_value, m_frame_last);
            results_seen++;
        end
    end

    task automatic send_item(logic [KIND_W-1:0] kind, logic [PIX_W-1:0] pix,
                             logic [CIDX_W-1:0] cidx, logic signed [COEF_W-1:0] cval);
        if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid = 0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid = 1;
        s_kind = kind;
        s_pixel_value = pix;
        s_coef_index = cidx;
        s_coef_value = cval;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(kind, pix, cidx, cval);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        cfg_we = 1;
        cfg_index = idx;
        cfg_wdata = val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 0;
    endtask

    task automatic set_geometry(int w, int h, int kw, int kh);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
        write_reg(CFG_KERNEL_WIDTH, CFG_W'(kw));
        write_reg(CFG_KERNEL_HEIGHT, CFG_W'(kh));
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coef();
        if ($urandom_range(0, 3) == 0) return COEF_W'($urandom());
        return COEF_W'($signed($urandom_range(0, 16383)) - 8192);
    endfunction

    task automatic load_kernel();
        for (int k = 0; k < KSTORE_N; k++)
            send_item(KIND_COEF, PIX_W'($urandom()), CIDX_W'(k), pick_coef());
    endtask

    // stream one frame with noise items mixed in; may abandon it part way
    task automatic run_frame(bit may_abort);
        int r;
        while (!sb.frame_done) begin
            r = $urandom_range(0, 99);
            if (r < 3) send_item(KIND_NONE, PIX_W'($urandom()), CIDX_W'($urandom()),
                                 COEF_W'($urandom()));
            else if (r < 6) send_item(KIND_COEF, PIX_W'($urandom()), CIDX_W'($urandom()),
                                      pick_coef());
            else begin
                send_item(r < 12 ? KIND_PAD : KIND_PIXEL, PIX_W'($urandom()),
                          CIDX_W'($urandom()), COEF_W'($urandom()));
                random_items++;
            end
            if (may_abort && $urandom_range(0, 399) == 0) break;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: 4x3 frame, coefficient extremes, ignored indexes, special items
        set_geometry(4, 3, 3, 3);
        send_item(KIND_COEF, '0, 6'd0, 18'sh1FFFF);
        send_item(KIND_COEF, '0, 6'd1, 18'sh20000);
        send_item(KIND_COEF, '0, 6'd4, 18'sh01000);
        send_item(KIND_COEF, '0, 6'd8, 18'sh3F000);
        send_item(KIND_COEF, '0, 6'd49, 18'sh1FFFF);
        send_item(KIND_COEF, '0, 6'd63, 18'sh20000);
        send_item(KIND_PIXEL, 8'hFF, '0, '0);
        send_item(KIND_PIXEL, 8'h00, '0, '0);
        send_item(KIND_PAD, 8'hFF, '0, '0);
        send_item(KIND_NONE, 8'hFF, 6'h3F, 18'sh1FFFF);
        send_item(KIND_PIXEL, 8'hFF, '0, '0);
        send_item(KIND_COEF, '0, 6'd48, 18'sh1FFFF);
        for (int k = 0; k < 7; k++) send_item(KIND_PIXEL, 8'hFF, '0, '0);
        send_item(KIND_PIXEL, 8'hAA, '0, '0);
        while (!sb.frame_done) send_item(KIND_PIXEL, 8'h55, '0, '0);

        // zero geometry acts as a single pixel with a 1x1 kernel
        set_geometry(0, 0, 0, 0);
        send_item(KIND_PIXEL, 8'hFF, '0, '0);
        send_item(KIND_PIXEL, 8'h01, '0, '0);

        // widest row, wide kernel: flushed by pixels past the frame
        idle_pct = 2;
        set_geometry(2047, 1, 7, 1);
        load_kernel();
        while (!sb.frame_done) send_item(KIND_PIXEL, PIX_W'($urandom()), '0, '0);

        random_items = 0;
        while (random_items < 100) begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 5;
                default: idle_pct = 25;
            endcase
            if (random_items > 60) quiet = 1;
            set_geometry($urandom_range(0, 12), $urandom_range(0, 6),
                         $urandom_range(0, 7), $urandom_range(0, 7));
            if ($urandom_range(0, 1)) load_kernel();
            run_frame(!quiet);
        end

        s_valid = 0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
